FILE: rtl/core/next_fit_page_frame_allocator_unit_assert.svh
// assertion macros for the next-fit page frame allocator
// used by the top level; needs a clk and an active-low rst_n in scope
`ifndef NEXT_FIT_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define NEXT_FIT_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition a in the same cycle implies c
`define NFPFA_ASSERT_NOW(name, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("nfpfa assertion failed");

// condition a implies c in the next cycle
`define NFPFA_ASSERT_NEXT(name, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("nfpfa assertion failed");

`else

`define NFPFA_ASSERT_NOW(name, a, c)
`define NFPFA_ASSERT_NEXT(name, a, c)

`endif

`endif

FILE: rtl/core/nfpfa_pkg.sv
// shared types and constants for the next-fit page frame allocator
// no dependencies
`timescale 1ns / 1ps

package nfpfa_pkg;

    // default sizing
    localparam int NUM_PAGES_DEF  = 1024;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int ID_BITS_DEF    = 16;

    // fixed field widths
    localparam int REQ_ID_W    = 16;
    localparam int BYTES_W     = 32;
    localparam int FREE_OFF_W  = 32;
    localparam int STATUS_W    = 3;
    localparam int PAGE_OFF_W  = 22;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED     = 3'd0,
        ST_TOO_LARGE     = 3'd1,
        ST_POOL_FULL     = 3'd2,
        ST_FREED         = 3'd3,
        ST_MISALIGNED    = 3'd4,
        ST_OUT_OF_RANGE  = 3'd5,
        ST_NOT_ALLOCATED = 3'd6,
        ST_WRONG_OWNER   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_ALLOC,
        FSM_FREE,
        FSM_DONE
    } fsm_state_t;

endpackage

FILE: rtl/core/next_fit_page_frame_allocator_unit.sv
// next-fit page frame allocator: one request in, one response out
// free and rejected requests answer from the free or done state; an allocate answers from the pointer's
// bitmap row when it has a free page, else reads further rows in turn until it wraps back to the start row
// a new request is only taken once the last one is answered, limited by the bitmap memory read-modify-write
// reset: asynchronous, active low; a clearing pass zeroes the in-use bitmap row by row before
// the first request is taken
`timescale 1ns / 1ps

`include "next_fit_page_frame_allocator_unit_assert.svh"

module next_fit_page_frame_allocator_unit #(
    parameter int NUM_PAGES  = nfpfa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = nfpfa_pkg::PAGE_BYTES_DEF,  // power of two
    parameter int ID_BITS    = nfpfa_pkg::ID_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // request channel
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic                                   operation,
    input  logic signed [nfpfa_pkg::REQ_ID_W-1:0]  requester_id,
    input  logic [nfpfa_pkg::BYTES_W-1:0]          request_bytes,
    input  logic [nfpfa_pkg::FREE_OFF_W-1:0]       free_offset,
    // response channel
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output logic [nfpfa_pkg::STATUS_W-1:0]         status,
    output logic [nfpfa_pkg::PAGE_OFF_W-1:0]       page_offset
);

    import nfpfa_pkg::*;

    // page index = {row, bit}; the bitmap is kept as rows of up to 32 pages
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PIDX_BITS  = $clog2(NUM_PAGES);
    localparam int BIT_W      = (PIDX_BITS > 5) ? 5 : ((PIDX_BITS > 1) ? PIDX_BITS - 1 : 1);
    localparam int ROW_W      = 1 << BIT_W;
    localparam int ROWS       = (NUM_PAGES + ROW_W - 1) / ROW_W;
    localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MEM_ROWS   = 1 << ROW_IDX_W;
    localparam int PIDX_W     = ROW_IDX_W + BIT_W;
    localparam int MEM_PAGES  = 1 << PIDX_W;
    localparam int CNT_W      = $clog2(ROWS + 2);
    localparam int FPAGE_W    = FREE_OFF_W - PAGE_SHIFT;
    localparam int OFF_FULL_W = PIDX_W + PAGE_SHIFT;

    // control state
    fsm_state_t             state_reg, state_next;
    logic [ROW_IDX_W-1:0]   row_reg, row_next;      // row under scan, or clearing row
    logic [CNT_W-1:0]       cnt_reg, cnt_next;      // rows read after the first in this scan
    logic [PIDX_W-1:0]      ptr_reg, ptr_next;      // next-fit pointer
    logic                   rsp_valid_reg, rsp_valid_next;

    // request payload held during the work
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [PIDX_W-1:0]      fpage_reg, fpage_next;
    status_t                pend_status_reg, pend_status_next;

    // response payload
    status_t                status_reg, status_next;
    logic [PAGE_OFF_W-1:0]  offset_reg, offset_next;

    // in-use bitmap, one bit per page
    logic [ROW_W-1:0]       bitmap_mem [MEM_ROWS];
    logic [ROW_W-1:0]       bm_rd_reg;
    logic                   bm_rd_en;
    logic [ROW_IDX_W-1:0]   bm_rd_addr;
    logic                   bm_wr_en;
    logic [ROW_IDX_W-1:0]   bm_wr_addr;
    logic [ROW_W-1:0]       bm_wr_data;

    // owner of each page; only meaningful while the page is in use
    logic [ID_BITS-1:0]     owner_mem [MEM_PAGES];
    logic [ID_BITS-1:0]     owner_rd_reg;
    logic                   own_rd_en;
    logic [PIDX_W-1:0]      own_rd_addr;
    logic                   own_wr_en;
    logic [PIDX_W-1:0]      own_wr_addr;

    // request decode
    logic signed [ID_BITS-1:0] id_ext;
    logic [FPAGE_W-1:0]        fpage_full;
    logic [PIDX_W-1:0]         fpage_in;
    logic                      out_free;

    // scan of the current bitmap row
    logic [ROW_W-1:0]       cand;
    logic                   hit;
    logic [BIT_W-1:0]       hit_bit;
    logic [PIDX_W-1:0]      hit_page;
    logic [PIDX_W:0]        hit_page_inc;
    logic [OFF_FULL_W-1:0]  hit_off_full;
    logic [ROW_IDX_W-1:0]   row_wrap;
    logic                   page_used;
    logic                   ptr_ok;

    assign id_ext     = ID_BITS'(requester_id);
    assign fpage_full = free_offset[FREE_OFF_W-1:PAGE_SHIFT];
    assign fpage_in   = PIDX_W'(fpage_full);
    // the response register can take a new value this cycle
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // candidate free pages in the row just read: inside the pool and inside the search window;
    // the first row read starts at the pointer, the last (same row again) stops before it
    always_comb
    begin
        logic [PIDX_W-1:0] pos;
        logic              in_window;
        cand = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            pos = {row_reg, BIT_W'(i)};
            if (cnt_reg == '0)
                in_window = BIT_W'(i) >= ptr_reg[BIT_W-1:0];
            else if (cnt_reg == CNT_W'(ROWS))
                in_window = BIT_W'(i) < ptr_reg[BIT_W-1:0];
            else
                in_window = 1'b1;
            cand[i] = !bm_rd_reg[i] && in_window && ({1'b0, pos} < (PIDX_W + 1)'(NUM_PAGES));
        end
    end

    // lowest free page in the window
    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(i);
            end
        end
    end

    assign hit_page     = {row_reg, hit_bit};
    assign hit_page_inc = {1'b0, hit_page} + (PIDX_W + 1)'(1);
    assign hit_off_full = {hit_page, PAGE_SHIFT'(0)};
    assign row_wrap     = (row_reg == ROW_IDX_W'(ROWS - 1)) ? '0 : row_reg + ROW_IDX_W'(1);
    assign page_used    = bm_rd_reg[fpage_reg[BIT_W-1:0]];
    assign ptr_ok       = {1'b0, ptr_reg} < (PIDX_W + 1)'(NUM_PAGES);

    // next state, memory controls and response
    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        cnt_next         = cnt_reg;
        ptr_next         = ptr_reg;
        id_next          = id_reg;
        fpage_next       = fpage_reg;
        pend_status_next = pend_status_reg;
        status_next      = status_reg;
        offset_next      = offset_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        bm_rd_en    = 1'b0;
        bm_rd_addr  = row_reg;
        bm_wr_en    = 1'b0;
        bm_wr_addr  = row_reg;
        bm_wr_data  = '0;
        own_rd_en   = 1'b0;
        own_rd_addr = fpage_in;
        own_wr_en   = 1'b0;
        own_wr_addr = hit_page;

        unique case (state_reg)
            FSM_CLEAR:
            begin
                // zero one bitmap row per cycle
                bm_wr_en   = 1'b1;
                bm_wr_addr = row_reg;
                bm_wr_data = '0;
                if (row_reg == ROW_IDX_W'(ROWS - 1))
                begin
                    row_next   = '0;
                    state_next = FSM_IDLE;
                end
                else
                begin
                    row_next = row_reg + ROW_IDX_W'(1);
                end
            end

            FSM_IDLE:
            begin
                if (req_valid)
                begin
                    id_next = id_ext;
                    if (operation == OP_ALLOC)
                    begin
                        if (request_bytes > BYTES_W'(PAGE_BYTES))
                        begin
                            pend_status_next = ST_TOO_LARGE;
                            state_next       = FSM_DONE;
                        end
                        else
                        begin
                            // start the scan at the pointer's row
                            bm_rd_en   = 1'b1;
                            bm_rd_addr = ptr_reg[PIDX_W-1:BIT_W];
                            row_next   = ptr_reg[PIDX_W-1:BIT_W];
                            cnt_next   = '0;
                            state_next = FSM_ALLOC;
                        end
                    end
                    else
                    begin
                        if (free_offset[PAGE_SHIFT-1:0] != '0)
                        begin
                            pend_status_next = ST_MISALIGNED;
                            state_next       = FSM_DONE;
                        end
                        else if (FREE_OFF_W'(fpage_full) >= FREE_OFF_W'(NUM_PAGES))
                        begin
                            pend_status_next = ST_OUT_OF_RANGE;
                            state_next       = FSM_DONE;
                        end
                        else
                        begin
                            // fetch the page's bitmap row and owner together
                            bm_rd_en    = 1'b1;
                            bm_rd_addr  = fpage_in[PIDX_W-1:BIT_W];
                            own_rd_en   = 1'b1;
                            own_rd_addr = fpage_in;
                            fpage_next  = fpage_in;
                            state_next  = FSM_FREE;
                        end
                    end
                end
            end

            FSM_ALLOC:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        bm_wr_en       = 1'b1;
                        bm_wr_addr     = row_reg;
                        bm_wr_data     = bm_rd_reg | (ROW_W'(1) << hit_bit);
                        own_wr_en      = 1'b1;
                        own_wr_addr    = hit_page;
                        ptr_next       = (hit_page_inc == (PIDX_W + 1)'(NUM_PAGES)) ?
                                         '0 : hit_page_inc[PIDX_W-1:0];
                        status_next    = ST_ALLOCATED;
                        offset_next    = PAGE_OFF_W'(hit_off_full);
                        rsp_valid_next = 1'b1;
                        state_next     = FSM_IDLE;
                    end
                end
                else if (cnt_reg == CNT_W'(ROWS))
                begin
                    // every row seen, wrapped back to the start row
                    if (out_free)
                    begin
                        status_next    = ST_POOL_FULL;
                        offset_next    = '0;
                        rsp_valid_next = 1'b1;
                        state_next     = FSM_IDLE;
                    end
                end
                else
                begin
                    bm_rd_en   = 1'b1;
                    bm_rd_addr = row_wrap;
                    row_next   = row_wrap;
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
            end

            FSM_FREE:
            begin
                if (out_free)
                begin
                    offset_next    = '0;
                    rsp_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                    if (!page_used)
                        status_next = ST_NOT_ALLOCATED;
                    else if (owner_rd_reg != id_reg && owner_rd_reg != '1)
                        status_next = ST_WRONG_OWNER;
                    else
                    begin
                        status_next = ST_FREED;
                        bm_wr_en    = 1'b1;
                        bm_wr_addr  = fpage_reg[PIDX_W-1:BIT_W];
                        bm_wr_data  = bm_rd_reg & ~(ROW_W'(1) << fpage_reg[BIT_W-1:0]);
                    end
                end
            end

            FSM_DONE:
            begin
                // rejected before any memory access
                if (out_free)
                begin
                    status_next    = pend_status_reg;
                    offset_next    = '0;
                    rsp_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_CLEAR;
            row_reg       <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        fpage_reg       <= fpage_next;
        pend_status_reg <= pend_status_next;
        status_reg      <= status_next;
        offset_reg      <= offset_next;
    end

    // bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (bm_wr_en)
            bitmap_mem[bm_wr_addr] <= bm_wr_data;
        if (bm_rd_en)
            bm_rd_reg <= bitmap_mem[bm_rd_addr];
    end

    // owner memory, registered read
    always_ff @(posedge clk)
    begin
        if (own_wr_en)
            owner_mem[own_wr_addr] <= id_reg;
        if (own_rd_en)
            owner_rd_reg <= owner_mem[own_rd_addr];
    end

    assign req_stall   = (state_reg != FSM_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign page_offset = offset_reg;

    // a taken request always leaves idle
    `NFPFA_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_reg != FSM_IDLE)
    // bitmap is never read and written in the same cycle
    `NFPFA_ASSERT_NOW(a_bitmap_no_overlap, bm_rd_en, !bm_wr_en)
    // next-fit pointer stays inside the pool
    `NFPFA_ASSERT_NOW(a_ptr_in_pool, 1'b1, ptr_ok)
    // only a successful allocate carries an offset
    `NFPFA_ASSERT_NOW(a_offset_zero, rsp_valid && status_reg != ST_ALLOCATED, page_offset == '0)
    // a new response only comes out of a working state
    `NFPFA_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid),
                      $past(state_reg) != FSM_IDLE && $past(state_reg) != FSM_CLEAR)

endmodule

FILE: test/tb_top.sv
// self-checking bench for next_fit_page_frame_allocator_unit: random and directed page requests
// depends on nfpfa_pkg and the allocator top level; expected responses come from a built-in model
`timescale 1ns / 1ps

module tb_top;
    import nfpfa_pkg::*;

    localparam int POOL_PAGES  = NUM_PAGES_DEF;
    localparam int FRAME_BYTES = PAGE_BYTES_DEF;
    localparam int PTR_W       = $clog2(POOL_PAGES);
    localparam logic [REQ_ID_W-1:0] KERNEL_ID = '1;

    typedef struct packed {
        logic                       op;
        logic signed [REQ_ID_W-1:0] id;
        logic [BYTES_W-1:0]         bytes;
        logic [FREE_OFF_W-1:0]      offset;
    } frame_req_t;

    typedef struct packed {
        status_t                status;
        logic [PAGE_OFF_W-1:0]  offset;
    } frame_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request side, all known from time zero
    logic                       req_valid     = 1'b0;
    logic                       req_stall;
    logic                       operation     = OP_ALLOC;
    logic signed [REQ_ID_W-1:0] requester_id  = '0;
    logic [BYTES_W-1:0]         request_bytes = '0;
    logic [FREE_OFF_W-1:0]      free_offset   = '0;

    // response side
    logic                       rsp_valid;
    logic                       rsp_stall     = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic [PAGE_OFF_W-1:0]      page_offset;

    always #5 clk = ~clk;

    next_fit_page_frame_allocator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .requester_id  (requester_id),
        .request_bytes (request_bytes),
        .free_offset   (free_offset),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .page_offset   (page_offset)
    );

    // ------------------------------------------------------------------
    // model of the pool: in-use bitmap, owners and the next-fit pointer
    // ------------------------------------------------------------------
    logic                page_busy  [POOL_PAGES];
    logic [REQ_ID_W-1:0] page_owner [POOL_PAGES];
    logic [PTR_W-1:0]    fit_ptr;

    function automatic frame_rsp_t predict_frame(input frame_req_t r);
        frame_rsp_t  rsp;
        int          idx;
        logic [31:0] page;
        logic        found;
        rsp.status = ST_POOL_FULL;
        rsp.offset = '0;
        found      = 1'b0;
        if (r.op == OP_ALLOC) begin
            if (r.bytes > FRAME_BYTES)
                rsp.status = ST_TOO_LARGE;
            else begin
                // first free page at or after the pointer, wrapping round the pool
                for (int k = 0; k < POOL_PAGES; k++) begin
                    idx = (int'(fit_ptr) + k) % POOL_PAGES;
                    if (!found && !page_busy[idx]) begin
                        found           = 1'b1;
                        page_busy[idx]  = 1'b1;
                        page_owner[idx] = r.id;
                        fit_ptr         = PTR_W'((idx + 1) % POOL_PAGES);
                        rsp.status      = ST_ALLOCATED;
                        rsp.offset      = PAGE_OFF_W'(idx * FRAME_BYTES);
                    end
                end
            end
        end else if (r.offset % FRAME_BYTES != 0)
            rsp.status = ST_MISALIGNED;
        else begin
            page = r.offset / FRAME_BYTES;
            if (page >= POOL_PAGES)
                rsp.status = ST_OUT_OF_RANGE;
            else if (!page_busy[page])
                rsp.status = ST_NOT_ALLOCATED;
            else if (page_owner[page] != r.id && page_owner[page] != KERNEL_ID)
                rsp.status = ST_WRONG_OWNER;
            else begin
                // the pointer stays where it is on a free
                page_busy[page]  = 1'b0;
                page_owner[page] = KERNEL_ID;
                rsp.status       = ST_FREED;
            end
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared by the stimulus, driver and monitor
    // ------------------------------------------------------------------
    frame_req_t pending_req [$];
    frame_rsp_t expected_rsp [$];
    frame_req_t on_bus;
    logic       req_taken = 1'b0;

    int issued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int failures       = 0;
    int status_hits [8];

    int send_idle_pct = 0;
    int stall_pct     = 0;

    // long response hold-off, armed once by the stimulus
    logic hold_armed = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;

    // rough tracking of the pool while generating, no timing involved
    int alloc_cursor = 0;
    int live_guess   = 0;

    // ------------------------------------------------------------------
    // driver: new request only once the current one has been taken
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        frame_req_t nxt;
        if (rst_n && (!req_valid || req_taken)) begin
            if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt           = pending_req.pop_front();
                on_bus        <= nxt;
                operation     <= nxt.op;
                requester_id  <= nxt.id;
                request_bytes <= nxt.bytes;
                free_offset   <= nxt.offset;
                req_valid     <= 1'b1;
            end else
                req_valid <= 1'b0;
        end
    end

    // response stall: random, or the one long hold when it is armed
    always @(negedge clk) begin
        if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_left <= 250;
            hold_done <= 1'b1;
        end else
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predict on acceptance, check on each response
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        frame_rsp_t want;
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall) begin
            expected_rsp.push_back(predict_frame(on_bus));
            accepted_count++;
        end
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
                failures++;
                $display("%0t ns: response with nothing expected, status %0d offset 'h%0h",
                         $time, status, page_offset);
            end else begin
                want = expected_rsp.pop_front();
                checked_count++;
                status_hits[want.status]++;
                if (status !== want.status) begin
                    failures++;
                    $display("%0t ns: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (page_offset !== want.offset) begin
                    failures++;
                    $display("%0t ns: page_offset expected 'h%0h actual 'h%0h",
                             $time, want.offset, page_offset);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_request(input logic op, input logic signed [REQ_ID_W-1:0] id,
                                input logic [BYTES_W-1:0] bytes,
                                input logic [FREE_OFF_W-1:0] offset);
        frame_req_t r;
        r = '{op: op, id: id, bytes: bytes, offset: offset};
        if (op == OP_ALLOC && bytes <= FRAME_BYTES) begin
            alloc_cursor = (alloc_cursor + 1) % POOL_PAGES;
            live_guess++;
        end else if (op == OP_FREE)
            live_guess--;
        issued_count++;
        pending_req.push_back(r);
    endtask

    task automatic wait_drained();
        while (checked_count != issued_count)
            @(posedge clk);
    endtask

    // small ids repeat often so that owners match now and then
    function automatic logic signed [REQ_ID_W-1:0] pick_id();
        int k;
        k = $urandom_range(0, 7);
        if (k == 0)
            return -1;
        else if (k <= 4)
            return REQ_ID_W'(k);
        else if (k == 5)
            return 16'sd32767;
        return REQ_ID_W'($urandom_range(0, 32767));
    endfunction

    task automatic run_phase(input int send_pct, input int hold_pct, input int n,
                             input int alloc_pct, input logic fill_pool);
        int          kind;
        logic [31:0] bytes;
        logic [31:0] offset;
        logic [31:0] pg;
        send_idle_pct = send_pct;
        stall_pct     = hold_pct;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 99) < alloc_pct) begin
                if (kind <= 6)
                    bytes = $urandom_range(0, FRAME_BYTES);
                else if (kind == 7)
                    bytes = $urandom_range(0, 1) ? FRAME_BYTES : 0;
                else if (kind == 8)
                    bytes = $urandom_range(FRAME_BYTES + 1, 32'hFFFF_FFFF);
                else
                    bytes = $urandom();
                push_request(OP_ALLOC, pick_id(), bytes, $urandom());
            end else begin
                if (kind <= 3)
                    // just behind the recent allocations, likely in use
                    pg = (alloc_cursor + 2 * POOL_PAGES - 1 - $urandom_range(0, 31))
                         % POOL_PAGES;
                else if (kind <= 5)
                    pg = $urandom_range(0, POOL_PAGES - 1);
                else
                    pg = $urandom_range(POOL_PAGES, 32'hF_FFFF);
                offset = pg * FRAME_BYTES;
                if (kind == 6) begin
                    offset = $urandom();
                    if (offset % FRAME_BYTES == 0)
                        offset[0] = 1'b1;
                end else if (kind == 8)
                    offset = $urandom();
                else if (kind == 9)
                    case ($urandom_range(0, 3))
                        0:       offset = 32'hFFFF_FFFF;
                        1:       offset = 32'hFFFF_F000;
                        2:       offset = (POOL_PAGES - 1) * FRAME_BYTES;
                        default: offset = POOL_PAGES * FRAME_BYTES;
                    endcase
                push_request(OP_FREE, pick_id(), $urandom(), offset);
            end
        end
        // enough allocations to be sure the pool runs full, then a few more
        if (fill_pool) begin
            while (live_guess < POOL_PAGES + 24)
                push_request(OP_ALLOC, pick_id(), $urandom_range(0, FRAME_BYTES), $urandom());
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < POOL_PAGES; i++) begin
            page_busy[i]  = 1'b0;
            page_owner[i] = KERNEL_ID;
        end
        fit_ptr = '0;
        foreach (status_hits[i])
            status_hits[i] = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: size limits, every free outcome, kernel pages, next-fit order
        push_request(OP_ALLOC, -1, 0, 32'hFFFF_FFFF);
        push_request(OP_ALLOC, 1, FRAME_BYTES, 0);
        push_request(OP_ALLOC, 2, FRAME_BYTES + 1, 0);
        push_request(OP_ALLOC, 3, 32'hFFFF_FFFF, 0);
        push_request(OP_FREE, 2, 0, FRAME_BYTES);
        push_request(OP_FREE, -1, 0, FRAME_BYTES);
        push_request(OP_FREE, 1, 32'hFFFF_FFFF, FRAME_BYTES);
        push_request(OP_FREE, 1, 0, FRAME_BYTES);
        push_request(OP_FREE, 5, 0, 0);
        push_request(OP_FREE, 1, 0, 1);
        push_request(OP_FREE, 1, 0, 32'hFFFF_FFFF);
        push_request(OP_FREE, 1, 0, FRAME_BYTES / 2);
        push_request(OP_FREE, 1, 0, POOL_PAGES * FRAME_BYTES);
        push_request(OP_FREE, 1, 0, 32'hFFFF_F000);
        push_request(OP_FREE, 1, 0, (POOL_PAGES - 1) * FRAME_BYTES);
        push_request(OP_ALLOC, 32767, 1, 32'h1234_5678);
        push_request(OP_ALLOC, 4, FRAME_BYTES - 1, 32'hFFFF_FFFF);
        push_request(OP_FREE, 3, 32'hFFFF_FFFF, 3 * FRAME_BYTES);
        push_request(OP_FREE, 32767, 32'hFFFF_FFFF, 2 * FRAME_BYTES);
        push_request(OP_FREE, -1, 0, 3 * FRAME_BYTES);
        push_request(OP_ALLOC, 7, 0, 0);
        wait_drained();

        run_phase(0, 0, 120, 90, 1'b0);
        run_phase(67, 0, 120, 90, 1'b0);
        // hold responses back while requests keep coming, so the input stalls
        hold_armed = 1'b1;
        run_phase(0, 0, 60, 70, 1'b0);
        run_phase(0, 67, 120, 90, 1'b1);
        // pool is full here: frees land on live pages, allocations wrap round
        run_phase(16, 16, 100, 30, 1'b0);

        // allow for a response still in flight after the last expected one
        repeat (40) @(posedge clk);

        $display("checked %0d responses over four idling mixes and a long response hold",
                 checked_count);
        $display("alloc %0d, too large %0d, full %0d, freed %0d, misaligned %0d,",
                 status_hits[ST_ALLOCATED], status_hits[ST_TOO_LARGE],
                 status_hits[ST_POOL_FULL], status_hits[ST_FREED],
                 status_hits[ST_MISALIGNED]);
        $display("out of range %0d, not allocated %0d, wrong owner %0d",
                 status_hits[ST_OUT_OF_RANGE], status_hits[ST_NOT_ALLOCATED],
                 status_hits[ST_WRONG_OWNER]);
        if (failures == 0 && expected_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // overall time limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d responses outstanding", issued_count - checked_count);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/nfpfa_pkg.sv
rtl/core/next_fit_page_frame_allocator_unit.sv
test/tb_top.sv
